// ===== src/vrth_pkg.sv =====
package vrth_pkg;

    localparam int FRAC_BITS = 8;
    localparam int QW = 24;   // quotient bits of the height correction
    localparam int RW = 57;   // divider remainder width

    localparam logic [2:0] REASON_HIT    = 3'd0;
    localparam logic [2:0] REASON_BOX    = 3'd1;
    localparam logic [2:0] REASON_DEGEN  = 3'd2;
    localparam logic [2:0] REASON_BARY   = 3'd3;
    localparam logic [2:0] REASON_BEHIND = 3'd4;

    typedef struct packed {
        logic [22:0]        point_x;
        logic [22:0]        point_y;
        logic signed [15:0] point_z;
        logic [14:0]        a_x;
        logic [14:0]        a_y;
        logic [14:0]        a_z;
        logic [14:0]        b_x;
        logic [14:0]        b_y;
        logic [14:0]        b_z;
        logic [14:0]        c_x;
        logic [14:0]        c_y;
        logic [14:0]        c_z;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [2:0]  reason;
        logic [23:0] distance;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        logic               box_out;
        logic signed [15:0] e1x;
        logic signed [15:0] e1y;
        logic signed [15:0] e1z;
        logic signed [15:0] e2x;
        logic signed [15:0] e2y;
        logic signed [15:0] e2z;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [24:0] k;
    } t_task;

    typedef struct packed {
        logic               neg;
        logic [RW-1:0]      mag;
        logic [31:0]        det;
        logic signed [24:0] k;
        logic [2:0]         reason;
    } t_div;

endpackage

// ===== src/vrth_front.sv =====
module vrth_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_acc,
    input  vrth_pkg::t_in   i_in,
    output logic            o_valid,
    output vrth_pkg::t_task o_task
);

    logic            r_valid;
    vrth_pkg::t_task r_task;
    vrth_pkg::t_task n_task;

    logic [22:0] sax, say, sbx, sby, scx, scy;
    logic signed [16:0] dz;
    logic        box_x, box_y;

    always_comb begin
        sax = {i_in.a_x, 8'b0};
        say = {i_in.a_y, 8'b0};
        sbx = {i_in.b_x, 8'b0};
        sby = {i_in.b_y, 8'b0};
        scx = {i_in.c_x, 8'b0};
        scy = {i_in.c_y, 8'b0};
        box_x = (i_in.point_x > sax && i_in.point_x > sbx && i_in.point_x > scx) ||
                (i_in.point_x < sax && i_in.point_x < sbx && i_in.point_x < scx);
        box_y = (i_in.point_y > say && i_in.point_y > sby && i_in.point_y > scy) ||
                (i_in.point_y < say && i_in.point_y < sby && i_in.point_y < scy);
        dz = $signed({2'b0, i_in.a_z}) - $signed({i_in.point_z[15], i_in.point_z});
        n_task.box_out = box_x || box_y;
        n_task.e1x = $signed({1'b0, i_in.b_x}) - $signed({1'b0, i_in.a_x});
        n_task.e1y = $signed({1'b0, i_in.b_y}) - $signed({1'b0, i_in.a_y});
        n_task.e1z = $signed({1'b0, i_in.b_z}) - $signed({1'b0, i_in.a_z});
        n_task.e2x = $signed({1'b0, i_in.c_x}) - $signed({1'b0, i_in.a_x});
        n_task.e2y = $signed({1'b0, i_in.c_y}) - $signed({1'b0, i_in.a_y});
        n_task.e2z = $signed({1'b0, i_in.c_z}) - $signed({1'b0, i_in.a_z});
        n_task.sx  = $signed({1'b0, i_in.point_x}) - $signed({1'b0, sax});
        n_task.sy  = $signed({1'b0, i_in.point_y}) - $signed({1'b0, say});
        n_task.k   = $signed({dz, 8'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_acc;
        end
        if (i_acc) begin
            r_task <= n_task;
        end
    end

    assign o_valid = r_valid;
    assign o_task  = r_task;

endmodule

// ===== src/vrth_queue.sv =====
module vrth_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vrth_pkg::t_task i_task,
    output logic            o_full,
    output logic            o_valid,
    output vrth_pkg::t_task o_task
);

    vrth_pkg::t_task r_mem [0:1];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            r_valid;
    vrth_pkg::t_task r_task;
    logic            pop;

    // the back end never stalls, so anything queued leaves next cycle
    assign pop = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt   <= r_cnt + 2'(i_push) - 2'(pop);
            r_valid <= pop;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_task;
        end
        if (pop) begin
            r_task <= r_mem[r_rp];
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = r_valid;
    assign o_task  = r_task;

endmodule

// ===== src/vrth_div.sv =====
module vrth_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  vrth_pkg::t_div              i_div,
    output logic                        o_valid,
    output logic [vrth_pkg::QW-1:0]     o_q,
    output logic                        o_rem_nz,
    output logic                        o_neg,
    output logic signed [24:0]          o_k,
    output logic [2:0]                  o_reason
);

    localparam int QW = vrth_pkg::QW;
    localparam int RW = vrth_pkg::RW;

    logic                 r_v   [0:QW];
    logic [RW-1:0]        r_rem [0:QW];
    logic [QW-1:0]        r_q   [0:QW];
    vrth_pkg::t_div       r_sd  [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0] <= i_div.mag;
        r_q[0]   <= '0;
        r_sd[0]  <= i_div;
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int SH = QW - 1 - j;
        logic [RW-1:0] dsh;
        logic          ge;

        assign dsh = RW'(r_sd[j].det) << SH;
        assign ge  = (r_rem[j] >= dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else begin
                r_v[j+1] <= r_v[j];
            end
            r_rem[j+1] <= ge ? r_rem[j] - dsh : r_rem[j];
            r_q[j+1]   <= {r_q[j][QW-2:0], ge};
            r_sd[j+1]  <= r_sd[j];
        end
    end

    assign o_valid  = r_v[QW];
    assign o_q      = r_q[QW];
    assign o_rem_nz = (r_rem[QW] != '0);
    assign o_neg    = r_sd[QW].neg;
    assign o_k      = r_sd[QW].k;
    assign o_reason = r_sd[QW].reason;

endmodule

// ===== src/vrth_back.sv =====
module vrth_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  vrth_pkg::t_task i_task,
    output logic            o_valid,
    output vrth_pkg::t_out  o_result
);

    // stage 1: products
    logic               r1_v, r1_box;
    logic signed [31:0] r1_d1, r1_d2;
    logic signed [39:0] r1_u1, r1_u2, r1_v1, r1_v2;
    logic signed [15:0] r1_e1z, r1_e2z;
    logic signed [24:0] r1_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_box <= i_task.box_out;
        r1_d1  <= i_task.e1y * i_task.e2x;
        r1_d2  <= i_task.e1x * i_task.e2y;
        r1_u1  <= i_task.sy * i_task.e2x;
        r1_u2  <= i_task.sx * i_task.e2y;
        r1_v1  <= i_task.sx * i_task.e1y;
        r1_v2  <= i_task.sy * i_task.e1x;
        r1_e1z <= i_task.e1z;
        r1_e2z <= i_task.e2z;
        r1_k   <= i_task.k;
    end

    // stage 2: determinant, sign fold, barycentric tests
    logic signed [32:0] det;
    logic signed [40:0] uu, vv;
    logic signed [41:0] uun, vvn, lim42;
    logic signed [42:0] sum, lim43;
    logic [31:0]        detm;
    logic [39:0]        lim;
    logic               dneg, bary_fail;
    logic [2:0]         n2_reason;

    always_comb begin
        det  = 33'(r1_d1) - 33'(r1_d2);
        uu   = 41'(r1_u1) - 41'(r1_u2);
        vv   = 41'(r1_v1) - 41'(r1_v2);
        dneg = det[32];
        detm = dneg ? 32'(-det) : 32'(det);
        uun  = dneg ? -42'(uu) : 42'(uu);
        vvn  = dneg ? -42'(vv) : 42'(vv);
        lim  = {detm, 8'b0};
        lim42 = $signed({2'b0, lim});
        lim43 = $signed({3'b0, lim});
        sum  = 43'(uun) + 43'(vvn);
        bary_fail = uun[41] || (uun > lim42) || vvn[41] || (sum > lim43);
        if (r1_box) begin
            n2_reason = vrth_pkg::REASON_BOX;
        end else if (det == '0) begin
            n2_reason = vrth_pkg::REASON_DEGEN;
        end else if (bary_fail) begin
            n2_reason = vrth_pkg::REASON_BARY;
        end else begin
            n2_reason = vrth_pkg::REASON_HIT;
        end
    end

    logic               r2_v;
    logic [2:0]         r2_reason;
    logic [31:0]        r2_det;
    logic [39:0]        r2_uu, r2_vv;
    logic signed [15:0] r2_e1z, r2_e2z;
    logic signed [24:0] r2_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_reason <= n2_reason;
        r2_det    <= detm;
        r2_uu     <= uun[39:0];
        r2_vv     <= vvn[39:0];
        r2_e1z    <= r1_e1z;
        r2_e2z    <= r1_e2z;
        r2_k      <= r1_k;
    end

    // stage 3: height weights as partial products of 20-bit slices
    logic               r3_v;
    logic [2:0]         r3_reason;
    logic [31:0]        r3_det;
    logic signed [24:0] r3_k;
    logic signed [36:0] r3_puh, r3_pul, r3_pvh, r3_pvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_reason <= r2_reason;
        r3_det    <= r2_det;
        r3_k      <= r2_k;
        r3_puh    <= $signed({1'b0, r2_uu[39:20]}) * r2_e1z;
        r3_pul    <= $signed({1'b0, r2_uu[19:0]}) * r2_e1z;
        r3_pvh    <= $signed({1'b0, r2_vv[39:20]}) * r2_e2z;
        r3_pvl    <= $signed({1'b0, r2_vv[19:0]}) * r2_e2z;
    end

    // combine, take magnitude for the divider
    logic signed [57:0] mh, m, mabs;
    vrth_pkg::t_div     dv;

    always_comb begin
        mh   = 58'(r3_puh) + 58'(r3_pvh);
        m    = (mh <<< 20) + 58'(r3_pul) + 58'(r3_pvl);
        mabs = m[57] ? -m : m;
        dv.neg    = m[57];
        dv.mag    = mabs[vrth_pkg::RW-1:0];
        dv.det    = r3_det;
        dv.k      = r3_k;
        dv.reason = r3_reason;
    end

    logic                    d_v, d_nz, d_neg;
    logic [vrth_pkg::QW-1:0] d_q;
    logic signed [24:0]      d_k;
    logic [2:0]              d_reason;

    vrth_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r3_v),
        .i_div    (dv),
        .o_valid  (d_v),
        .o_q      (d_q),
        .o_rem_nz (d_nz),
        .o_neg    (d_neg),
        .o_k      (d_k),
        .o_reason (d_reason)
    );

    // floor quotient, add base height, saturate
    logic [25:0]    qs;
    logic [26:0]    total;
    vrth_pkg::t_out n_res;

    always_comb begin
        qs    = d_neg ? (-26'(d_q) - 26'(d_nz)) : 26'(d_q);
        total = 27'(d_k) + {qs[25], qs};
        n_res = '0;
        if (d_reason != vrth_pkg::REASON_HIT) begin
            n_res.reason = d_reason;
        end else if (total[26]) begin
            n_res.reason = vrth_pkg::REASON_BEHIND;
        end else begin
            n_res.hit      = 1'b1;
            n_res.reason   = vrth_pkg::REASON_HIT;
            n_res.distance = (total[25:24] != 2'b0) ? 24'hFFFFFF : total[23:0];
        end
    end

    logic           r_v;
    vrth_pkg::t_out r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= d_v;
        end
        r_res <= n_res;
    end

    assign o_valid  = r_v;
    assign o_result = r_res;

endmodule

// ===== src/vertical_ray_triangle_hit.sv =====
// Upward ray against one triangle: each transaction taken on start (busy low)
// gives exactly one result on o_result, marked by o_valid for one cycle, in
// acceptance order. A new transaction may start every cycle while busy is low.
// The front classifier registers at the accepting edge itself; after it come
// the queue hand-off, three arithmetic stages for the products, the
// determinant and barycentric tests and the height weights, the restoring
// divider that forms the height correction (its input register plus 24
// quotient stages) and the output register. The receiver cannot stall, so
// busy stays low in operation.
module vertical_ray_triangle_hit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  vrth_pkg::t_in  i_in,
    output logic           o_valid,
    output vrth_pkg::t_out o_result
);

    logic            f_valid, q_valid, q_full;
    vrth_pkg::t_task f_task, q_task;

    assign busy = q_full;

    vrth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (start && !busy),
        .i_in    (i_in),
        .o_valid (f_valid),
        .o_task  (f_task)
    );

    vrth_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_task  (f_task),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_task  (q_task)
    );

    vrth_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_task   (q_task),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
